// File: design/sdcc_pkg.sv
// ----------------------------------------------------------------------------
// sdcc_pkg
// Shared types and constants of the span dependency cycle check block.
// ----------------------------------------------------------------------------
package sdcc_pkg;

  // default graph size; rows, marks and stack follow from it
  localparam int DEF_MAX_COLUMNS = 32;

  // fixed field widths
  localparam int ANCHOR_W    = 5;
  localparam int REACH_W     = 5;
  localparam int COUNT_W     = 6;
  localparam int SPAN_W      = 7;   // holds anchor + reach and column counts up to 64
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  // request kinds carried on in_tuser
  localparam logic KIND_SPAN = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_WR,
    ST_ROOT,
    ST_STEP,
    ST_POP,
    ST_DONE
  } sdcc_state_t;

endpackage

// File: design/span_dependency_cycle_check.sv
// ----------------------------------------------------------------------------
// span_dependency_cycle_check
// Loads span requests into an adjacency row memory and, on an evaluate
// request, runs a depth-first walk to report a directed cycle.
// ----------------------------------------------------------------------------
//
//  channel  direction  payload                                      handshake
//  -------  ---------  -------------------------------------------  ---------------
//  in_      slave      tdata: anchor, reach_left, reach_right;      tvalid/tready
//                      tuser: kind
//  out_     master     tdata: has_cycle                             tvalid/tready
//  cfg_     write      wr_data: column_count                        wr_en, no wait
//
//  a span request that changes nothing is taken without leaving idle; any other
//  span request does a read-modify-write of one adjacency row through the row
//  memory read and write ports; an evaluate request holds the block for at most
//  one root pick per tree plus a closing one, one walk step per non-root push and
//  per finished node, one stack read per finished non-root node, and one step to
//  post the result
//  in_tready is low while a request is at work; the result sits in an output
//  register, so a stalled out_ side only holds the block at the end of an evaluate
//  reset is synchronous; no clearing pass is needed, row valid bits clear at once
// ----------------------------------------------------------------------------
module span_dependency_cycle_check #(
  parameter int MAX_COLUMNS = sdcc_pkg::DEF_MAX_COLUMNS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // request channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [sdcc_pkg::IN_TDATA_W-1:0]    in_tdata,   // anchor, reach_left, reach_right, pad
  input  logic                               in_tuser,   // kind
  // result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [sdcc_pkg::OUT_TDATA_W-1:0]   out_tdata,  // has_cycle, pad
  // configuration
  input  logic                               cfg_wr_en,
  input  logic [sdcc_pkg::COUNT_W-1:0]       cfg_wr_data // column_count
);
  import sdcc_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS);      // node index width
  localparam int DW = $clog2(MAX_COLUMNS + 1);  // stack depth width

  // request fields
  logic [ANCHOR_W-1:0] in_anchor;
  logic [REACH_W-1:0]  in_left;
  logic [REACH_W-1:0]  in_right;
  logic                in_fire;

  assign in_anchor = in_tdata[ANCHOR_W-1:0];
  assign in_left   = in_tdata[ANCHOR_W+REACH_W-1:ANCHOR_W];
  assign in_right  = in_tdata[ANCHOR_W+2*REACH_W-1:ANCHOR_W+REACH_W];
  assign in_fire   = in_tvalid && in_tready;

  // control state
  sdcc_state_t            state_r, state_nxt;
  logic [COUNT_W-1:0]     column_count_r;
  logic [MAX_COLUMNS-1:0] row_vld_r, row_vld_nxt;
  logic [MAX_COLUMNS-1:0] on_path_r, on_path_nxt;   // on the current walk
  logic [MAX_COLUMNS-1:0] done_r, done_nxt;         // fully explored
  logic [DW-1:0]          depth_r, depth_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // payload state
  logic [CW-1:0]          node_r, node_nxt;
  logic [CW-1:0]          anchor_r, anchor_nxt;
  logic [MAX_COLUMNS-1:0] span_r, span_nxt;
  logic                   res_r, res_nxt;
  logic                   out_cyc_r, out_cyc_nxt;

  // memories: adjacency rows and walk stack
  logic [MAX_COLUMNS-1:0] edge_mem [MAX_COLUMNS];
  logic [CW-1:0]          stack_mem [MAX_COLUMNS];
  logic [MAX_COLUMNS-1:0] edge_rd_r;
  logic                   edge_vld_rd_r;
  logic [CW-1:0]          stack_rd_r;

  logic [CW-1:0]          edge_raddr;
  logic                   edge_we;
  logic [MAX_COLUMNS-1:0] edge_wdata;
  logic                   stk_we;
  logic [CW-1:0]          stk_waddr;
  logic [CW-1:0]          stk_raddr;

  // live node set, clamped to the parameter
  logic [SPAN_W-1:0]      live_n;
  logic [MAX_COLUMNS-1:0] node_mask;

  assign live_n = ({1'b0, column_count_r} > SPAN_W'(MAX_COLUMNS)) ?
                  SPAN_W'(MAX_COLUMNS) : {1'b0, column_count_r};

  always_comb begin
    for (int i = 0; i < MAX_COLUMNS; i++) begin
      node_mask[i] = (SPAN_W'(i) < live_n);
    end
  end

  // span range of an incoming request, clamped to the live columns
  logic [SPAN_W-1:0]      anchor_x, left_x, right_x;
  logic [SPAN_W-1:0]      span_first, span_room, span_reach, span_last;
  logic                   span_active;
  logic [MAX_COLUMNS-1:0] span_mask;

  always_comb begin
    anchor_x    = SPAN_W'(in_anchor);
    left_x      = SPAN_W'(in_left);
    right_x     = SPAN_W'(in_right);
    span_first  = (anchor_x > left_x) ? (anchor_x - left_x) : '0;
    span_room   = live_n - SPAN_W'(1) - anchor_x;
    span_reach  = (right_x < span_room) ? right_x : span_room;
    span_last   = anchor_x + span_reach;
    span_active = ((in_left != '0) || (in_right != '0)) && (anchor_x < live_n);
    for (int i = 0; i < MAX_COLUMNS; i++) begin
      span_mask[i] = (SPAN_W'(i) >= span_first) && (SPAN_W'(i) <= span_last) &&
                     (SPAN_W'(i) != anchor_x);
    end
  end

  // row of the node on top of the walk, as read from the row memory
  logic [MAX_COLUMNS-1:0] cur_row, live_row, cand;

  assign cur_row  = edge_vld_rd_r ? edge_rd_r : '0;
  assign live_row = cur_row & node_mask;
  // successors neither on the walk nor finished
  assign cand     = live_row & ~on_path_r & ~done_r;

  // shared find-first unit: picks the next root or the next successor
  logic [MAX_COLUMNS-1:0] ff_vec;
  logic [CW-1:0]          ff_idx;
  logic                   ff_any;

  assign ff_vec = (state_r == ST_ROOT) ? (node_mask & ~done_r) : cand;
  assign ff_any = |ff_vec;

  always_comb begin
    ff_idx = '0;
    for (int i = MAX_COLUMNS - 1; i >= 0; i--) begin
      if (ff_vec[i]) begin
        ff_idx = CW'(i);
      end
    end
  end

  // parent of the node being popped sits two below the current depth
  logic [DW-1:0] depth_less2;
  assign depth_less2 = depth_r - DW'(2);
  assign stk_raddr   = depth_less2[CW-1:0];
  assign edge_wdata  = cur_row | span_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    row_vld_nxt   = row_vld_r;
    on_path_nxt   = on_path_r;
    done_nxt      = done_r;
    depth_nxt     = depth_r;
    out_valid_nxt = out_valid_r && !out_tready;
    node_nxt      = node_r;
    anchor_nxt    = anchor_r;
    span_nxt      = span_r;
    res_nxt       = res_r;
    out_cyc_nxt   = out_cyc_r;
    edge_raddr    = node_r;
    edge_we       = 1'b0;
    stk_we        = 1'b0;
    stk_waddr     = depth_r[CW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser == KIND_EVAL) begin
            state_nxt = ST_ROOT;
          end else if (span_active) begin
            // fetch the anchor row, merge it next cycle
            edge_raddr = CW'(in_anchor);
            anchor_nxt = CW'(in_anchor);
            span_nxt   = span_mask;
            state_nxt  = ST_LOAD_WR;
          end
        end
      end
      ST_LOAD_WR: begin
        edge_we               = 1'b1;
        row_vld_nxt[anchor_r] = 1'b1;
        state_nxt             = ST_IDLE;
      end
      ST_ROOT: begin
        if (ff_any) begin
          on_path_nxt[ff_idx] = 1'b1;
          stk_we              = 1'b1;
          stk_waddr           = '0;
          node_nxt            = ff_idx;
          depth_nxt           = DW'(1);
          edge_raddr          = ff_idx;
          state_nxt           = ST_STEP;
        end else begin
          res_nxt   = 1'b0;
          state_nxt = ST_DONE;
        end
      end
      ST_STEP: begin
        if ((live_row & on_path_r) != '0) begin
          // back edge to a node on the walk
          res_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else if (ff_any) begin
          on_path_nxt[ff_idx] = 1'b1;
          stk_we              = 1'b1;
          node_nxt            = ff_idx;
          depth_nxt           = depth_r + DW'(1);
          edge_raddr          = ff_idx;
        end else begin
          done_nxt[node_r]    = 1'b1;
          on_path_nxt[node_r] = 1'b0;
          depth_nxt           = depth_r - DW'(1);
          if (depth_r == DW'(1)) begin
            state_nxt = ST_ROOT;
          end else begin
            state_nxt = ST_POP;
          end
        end
      end
      ST_POP: begin
        node_nxt   = stack_rd_r;
        edge_raddr = stack_rd_r;
        state_nxt  = ST_STEP;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_cyc_nxt   = res_r;
          row_vld_nxt   = '0;
          on_path_nxt   = '0;
          done_nxt      = '0;
          depth_nxt     = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      column_count_r <= '0;
      row_vld_r      <= '0;
      on_path_r      <= '0;
      done_r         <= '0;
      depth_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_vld_r   <= row_vld_nxt;
      on_path_r   <= on_path_nxt;
      done_r      <= done_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        column_count_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    node_r    <= node_nxt;
    anchor_r  <= anchor_nxt;
    span_r    <= span_nxt;
    res_r     <= res_nxt;
    out_cyc_r <= out_cyc_nxt;
  end

  // row memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[anchor_r] <= edge_wdata;
    end
    edge_rd_r     <= edge_mem[edge_raddr];
    edge_vld_rd_r <= row_vld_r[edge_raddr];
  end

  // walk stack memory
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= ff_idx;
    end
    stack_rd_r <= stack_mem[stk_raddr];
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_cyc_r};

endmodule

// File: design/sdcc_checker.sv
// ----------------------------------------------------------------------------
// sdcc_checker
// Port-level checks of the span dependency cycle check block.
// ----------------------------------------------------------------------------
module sdcc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [sdcc_pkg::IN_TDATA_W-1:0]    in_tdata,
  input logic                               in_tuser,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [sdcc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic                               cfg_wr_en,
  input logic [sdcc_pkg::COUNT_W-1:0]       cfg_wr_data
);
  import sdcc_pkg::*;

  // a held result keeps its value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a span request never produces a result
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == KIND_SPAN) && !out_tvalid |=> !out_tvalid)
    else $error("result after span request");

  // an evaluate request keeps the block busy for the walk
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == KIND_EVAL) |=> !in_tready)
    else $error("ready right after evaluate request");

  // padding of the result stays zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_TDATA_W-1:1] == '0))
    else $error("result padding not zero");

  // reset drops the result
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind span_dependency_cycle_check sdcc_checker u_sdcc_checker (.*);
